[rtl/tbges_pkg.sv]
package tbges_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY   = 2'd1;

   localparam int REG_W    = 21;
   localparam int WORD_W   = 32;
   localparam int MAG_W    = 32;          // |self - other| per axis
   localparam int SQR_W    = 64;          // |d|^2 per axis
   localparam int R2_W     = 65;          // dx^2 + dy^2
   localparam int ROOT_W   = 33;          // floor(sqrt(r2))
   localparam int SQ_STEPS = ROOT_W;      // one root bit per stage
   localparam int SQ_REM_W = 37;
   localparam int GM_W     = 53;          // G * mass
   localparam int NUM0_W   = 85;          // G * mass * |d| before scaling
   localparam int DEN_W    = 98;          // r2 * r
   localparam int QUO_W    = 63;          // quotient bits kept below the overflow test
   localparam int DIV_LAT  = QUO_W + 1;
   localparam int PROD_W   = 84;          // acceleration * time step
   localparam int DV_W     = 41;
   localparam int PM_W     = 53;          // |v'| * time step

   // G scaled by 2^25, rounded; reset value of the gravity register derives from it
   localparam longint unsigned G_AT_25 = 64'd2239524;

   localparam logic [QUO_W-1:0] ACC_CAP = QUO_W'(64'd1 << 62);
   localparam logic [DV_W-1:0]  DV_CAP  = DV_W'(64'd1 << 40);

   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   // what travels alongside the arithmetic
   typedef struct packed {
      logic [1:0][WORD_W-1:0] pos;
      logic [1:0][WORD_W-1:0] vel;
      logic [1:0]             ahead;   // self beyond other on that axis
      logic                   coinc;
   } side_type;

   typedef struct packed {
      logic [R2_W-1:0]       r2;
      logic [1:0][MAG_W-1:0] mag;
      logic [GM_W-1:0]       gm;
      side_type              side;
   } sq_type;

endpackage

[rtl/tbges_div.sv]
module tbges_div
   import tbges_pkg::*;
#(
   parameter int NUM_W = 109
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int REM_W = DEN_W + 1;
   localparam int HI_W  = NUM_W - QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [REM_W-1:0] hi_in;
   assign hi_in = {{(REM_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};

   // quotient of 2^63 or more: flag it, the remaining steps run on regardless
   always_ff @(posedge clock) begin
      if (adv) begin
         ovf_ff[0] <= hi_in >= {1'b0, den};
         rem_ff[0] <= hi_in;
         den_ff[0] <= den;
         low_ff[0] <= num[QUO_W-1:0];
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int B = QUO_W - 1 - k;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;
      logic             ge;

      always_comb begin
         rem_sh = {rem_ff[k][REM_W-2:0], low_ff[k][B]};
         ge     = rem_sh >= {1'b0, den_ff[k]};
         rem_in = ge ? rem_sh - {1'b0, den_ff[k]} : rem_sh;
         quo_in = quo_ff[k];
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= rem_in;
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= low_ff[k];
            quo_ff[k+1] <= quo_in;
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

[rtl/two_body_gravity_euler_step.sv]
// One semi-implicit Euler step of a body under the pull of a second body, in signed
// fixed point with FRAC_BITS fraction bits (mass is unsigned Q24.8). A word can be taken
// every cycle while the result side does not stall; the path holds the 33-stage square
// root (one root bit a stage) and the 64-stage divider (an overflow test, then one quotient
// bit a stage) that form G*m*|d|/|d|^3. A stall on the result side freezes the whole pipe.
// Write the time step and gravity constant only while the pipe is empty.
module two_body_gravity_euler_step
   import tbges_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [31:0]    req_self_x,
   input  logic signed [31:0]    req_self_y,
   input  logic signed [31:0]    req_self_vel_x,
   input  logic signed [31:0]    req_self_vel_y,
   input  logic signed [31:0]    req_other_x,
   input  logic signed [31:0]    req_other_y,
   input  logic [31:0]           req_other_mass,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_new_x,
   output logic signed [31:0]    rsp_new_y,
   output logic signed [31:0]    rsp_new_vel_x,
   output logic signed [31:0]    rsp_new_vel_y,
   output logic                  rsp_coincident,
   output logic                  rsp_saturated
);

   localparam int SHIFT = 2*FRAC_BITS - 8;
   localparam int NUM_W = NUM0_W + SHIFT;
   localparam int LAT   = 4 + SQ_STEPS + 2 + DIV_LAT + 8;

   localparam longint unsigned ONE     = 64'd1 << FRAC_BITS;
   localparam longint unsigned REG_MAX = (64'd1 << REG_W) - 64'd1;
   localparam logic [REG_W-1:0] TS_RST = (ONE > REG_MAX) ? REG_W'(REG_MAX) : REG_W'(ONE);
   localparam logic [REG_W-1:0] G_RST  =
      REG_W'(((G_AT_25 >> (24 - FRAC_BITS)) + 64'd1) >> 1);

   logic [REG_W-1:0] time_step_ff;
   logic [REG_W-1:0] gravity_ff;
   logic [LAT-1:0]   vld_ff;
   logic             adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TS_RST;
         gravity_ff   <= G_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata;
            CSR_GRAVITY:   gravity_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the pipe moves unless a finished word is held at the output
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // capture
   logic [1:0][WORD_W-1:0] a_pos_ff, a_vel_ff, a_oth_ff;
   logic [31:0]            a_mass_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_pos_ff  <= {req_self_y, req_self_x};
         a_vel_ff  <= {req_self_vel_y, req_self_vel_x};
         a_oth_ff  <= {req_other_y, req_other_x};
         a_mass_ff <= req_other_mass;
      end
   end

   // distance per axis, G * mass
   side_type               b_side_in, b_side_ff;
   logic [1:0][MAG_W-1:0]  b_mag_in, b_mag_ff;
   logic [GM_W-1:0]        b_gm_ff;

   always_comb begin
      logic [32:0] diff [2];
      b_side_in.pos = a_pos_ff;
      b_side_in.vel = a_vel_ff;
      for (int a = 0; a < 2; a++) begin
         diff[a] = {a_pos_ff[a][31], a_pos_ff[a]} - {a_oth_ff[a][31], a_oth_ff[a]};
         b_mag_in[a] = diff[a][32] ? MAG_W'(33'd0 - diff[a]) : diff[a][31:0];
         b_side_in.ahead[a] = !diff[a][32] && (diff[a] != '0);
      end
      b_side_in.coinc = (diff[0] == '0) && (diff[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_side_ff <= b_side_in;
         b_mag_ff  <= b_mag_in;
         b_gm_ff   <= GM_W'(gravity_ff) * GM_W'(a_mass_ff);
      end
   end

   // squares
   side_type              c_side_ff;
   logic [1:0][MAG_W-1:0] c_mag_ff;
   logic [GM_W-1:0]       c_gm_ff;
   logic [SQR_W-1:0]      c_sq_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= b_side_ff;
         c_mag_ff  <= b_mag_ff;
         c_gm_ff   <= b_gm_ff;
         for (int a = 0; a < 2; a++) begin
            c_sq_ff[a] <= SQR_W'(b_mag_ff[a]) * SQR_W'(b_mag_ff[a]);
         end
      end
   end

   // square root, one bit a stage
   sq_type                sq_ff   [SQ_STEPS+1];
   logic [ROOT_W-1:0]     root_ff [SQ_STEPS+1];
   logic [SQ_REM_W-1:0]   srem_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].r2   <= R2_W'(c_sq_ff[0]) + R2_W'(c_sq_ff[1]);
         sq_ff[0].mag  <= c_mag_ff;
         sq_ff[0].gm   <= c_gm_ff;
         sq_ff[0].side <= c_side_ff;
         root_ff[0]    <= '0;
         srem_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int I = SQ_STEPS - 1 - k;
      logic [R2_W:0]         pad;
      logic [SQ_REM_W-1:0]   rem_sh, trial, rem_in;
      logic [ROOT_W-1:0]     root_in;

      always_comb begin
         pad    = {1'b0, sq_ff[k].r2};
         rem_sh = {srem_ff[k][SQ_REM_W-3:0], pad[2*I+1 -: 2]};
         trial  = {2'b00, root_ff[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1]   <= sq_ff[k];
            root_ff[k+1] <= root_in;
            srem_ff[k+1] <= rem_in;
         end
      end
   end

   // partial products of r2*r and G*m*|d|
   sq_type              e_src;
   side_type            e_side_ff;
   logic [64:0]         e_dlo_ff;
   logic [65:0]         e_dhi_ff;
   logic [63:0]         e_nlo_ff [2];
   logic [52:0]         e_nhi_ff [2];

   assign e_src = sq_ff[SQ_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= e_src.side;
         e_dlo_ff  <= 65'(e_src.r2[31:0]) * 65'(root_ff[SQ_STEPS]);
         e_dhi_ff  <= 66'(e_src.r2[64:32]) * 66'(root_ff[SQ_STEPS]);
         for (int a = 0; a < 2; a++) begin
            e_nlo_ff[a] <= 64'(e_src.gm[31:0]) * 64'(e_src.mag[a]);
            e_nhi_ff[a] <= 53'(e_src.gm[52:32]) * 53'(e_src.mag[a]);
         end
      end
   end

   side_type         f_side_ff;
   logic [DEN_W-1:0] f_den_ff;
   logic [NUM_W-1:0] f_num_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         f_side_ff <= e_side_ff;
         f_den_ff  <= DEN_W'(e_dlo_ff) + {e_dhi_ff, 32'd0};
         for (int a = 0; a < 2; a++) begin
            f_num_ff[a] <= {NUM0_W'(e_nlo_ff[a]) + {e_nhi_ff[a], 32'd0}, {SHIFT{1'b0}}};
         end
      end
   end

   // divide, both axes side by side; side data follows on a delay line
   logic [QUO_W-1:0] quo [2];
   logic [1:0]       ovf;
   side_type         dl_ff [DIV_LAT];

   for (genvar a = 0; a < 2; a++) begin : g_div
      tbges_div #(
         .NUM_W (NUM_W)
      ) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (f_num_ff[a]),
         .den   (f_den_ff),
         .quo   (quo[a]),
         .ovf   (ovf[a])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[0] <= f_side_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            dl_ff[j] <= dl_ff[j-1];
         end
      end
   end

   // clamp acceleration
   side_type         g_side_ff;
   logic [QUO_W-1:0] g_acc_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         g_side_ff <= dl_ff[DIV_LAT-1];
         for (int a = 0; a < 2; a++) begin
            g_acc_ff[a] <= (ovf[a] || (quo[a][62] && (quo[a][61:0] != '0))) ?
                           ACC_CAP : quo[a];
         end
      end
   end

   // acceleration * time step
   side_type    h_side_ff;
   logic [52:0] h_pl_ff [2];
   logic [51:0] h_ph_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         h_side_ff <= g_side_ff;
         for (int a = 0; a < 2; a++) begin
            h_pl_ff[a] <= 53'(g_acc_ff[a][31:0]) * 53'(time_step_ff);
            h_ph_ff[a] <= 52'(g_acc_ff[a][62:32]) * 52'(time_step_ff);
         end
      end
   end

   side_type          i_side_ff;
   logic [PROD_W-1:0] i_p_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         i_side_ff <= h_side_ff;
         for (int a = 0; a < 2; a++) begin
            i_p_ff[a] <= PROD_W'(h_pl_ff[a]) + {h_ph_ff[a], 32'd0};
         end
      end
   end

   side_type        j_side_ff;
   logic [DV_W-1:0] j_dv_ff [2];

   always_ff @(posedge clock) begin
      logic [PROD_W-1:0] ps;
      if (adv) begin
         j_side_ff <= i_side_ff;
         for (int a = 0; a < 2; a++) begin
            ps = i_p_ff[a] >> FRAC_BITS;
            j_dv_ff[a] <= (ps > PROD_W'(DV_CAP)) ? DV_CAP : ps[DV_W-1:0];
         end
      end
   end

   // new velocity, saturated; coincident bodies keep their velocity
   side_type k_side_in, k_side_ff;
   logic     k_sat_in, k_sat_ff;

   always_comb begin
      logic [42:0] sv, dv, nw;
      logic        over;
      k_side_in = j_side_ff;
      k_sat_in  = 1'b0;
      for (int a = 0; a < 2; a++) begin
         sv   = {{11{j_side_ff.vel[a][31]}}, j_side_ff.vel[a]};
         dv   = {2'b00, j_dv_ff[a]};
         nw   = j_side_ff.ahead[a] ? sv - dv : sv + dv;
         over = nw[42:31] != {12{nw[42]}};
         if (!j_side_ff.coinc) begin
            k_side_in.vel[a] = over ? (nw[42] ? WORD_MIN : WORD_MAX) : nw[31:0];
            k_sat_in = k_sat_in | over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_side_ff <= k_side_in;
         k_sat_ff  <= k_sat_in;
      end
   end

   side_type          l_side_ff;
   logic              l_sat_ff;
   logic [WORD_W-1:0] l_mag_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         l_side_ff <= k_side_ff;
         l_sat_ff  <= k_sat_ff;
         for (int a = 0; a < 2; a++) begin
            l_mag_ff[a] <= k_side_ff.vel[a][31] ? 32'd0 - k_side_ff.vel[a] : k_side_ff.vel[a];
         end
      end
   end

   side_type        m_side_ff;
   logic            m_sat_ff;
   logic [PM_W-1:0] m_prod_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         m_side_ff <= l_side_ff;
         m_sat_ff  <= l_sat_ff;
         for (int a = 0; a < 2; a++) begin
            m_prod_ff[a] <= PM_W'(l_mag_ff[a]) * PM_W'(time_step_ff);
         end
      end
   end

   // new position from the new velocity, saturated
   logic [1:0][WORD_W-1:0] n_pos_in;
   logic [1:0]             n_over;

   always_comb begin
      logic [PM_W-1:0] m;
      logic [54:0]     sw, mw, nw;
      for (int a = 0; a < 2; a++) begin
         m  = m_prod_ff[a] >> FRAC_BITS;
         sw = {{23{m_side_ff.pos[a][31]}}, m_side_ff.pos[a]};
         mw = {2'b00, m};
         nw = m_side_ff.vel[a][31] ? sw - mw : sw + mw;
         n_over[a]   = nw[54:31] != {24{nw[54]}};
         n_pos_in[a] = n_over[a] ? (nw[54] ? WORD_MIN : WORD_MAX) : nw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_new_x      <= n_pos_in[0];
         rsp_new_y      <= n_pos_in[1];
         rsp_new_vel_x  <= m_side_ff.vel[0];
         rsp_new_vel_y  <= m_side_ff.vel[1];
         rsp_coincident <= m_side_ff.coinc;
         rsp_saturated  <= m_sat_ff | (|n_over);
      end
   end

   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("word taken while the output is held");

   a_take_in: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while the pipe can move");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipe moved during an output stall");

endmodule

[tb/gravity_step_checker.sv]
module gravity_step_checker
   import tbges_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [31:0]   req_self_x,
   input  logic signed [31:0]   req_self_y,
   input  logic signed [31:0]   req_self_vel_x,
   input  logic signed [31:0]   req_self_vel_y,
   input  logic signed [31:0]   req_other_x,
   input  logic signed [31:0]   req_other_y,
   input  logic [31:0]          req_other_mass,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [31:0]   rsp_new_x,
   input  logic signed [31:0]   rsp_new_y,
   input  logic signed [31:0]   rsp_new_vel_x,
   input  logic signed [31:0]   rsp_new_vel_y,
   input  logic                 rsp_coincident,
   input  logic                 rsp_saturated,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int SCALE = 2 * FRAC - 8;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               coinc;
      logic               sat;
   } body_state_type;

   logic [REG_W-1:0] step_reg;
   logic [REG_W-1:0] grav_reg;
   body_state_type   body_queue[$];

   function automatic logic [127:0] root_floor(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic [127:0] kick_mag(logic [127:0] dmag, logic [127:0] den,
                                             logic [127:0] gm);
      logic [127:0] q;
      logic [127:0] p;
      q = ((gm * dmag) << SCALE) / den;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      p = (q * 128'(step_reg)) >> FRAC;
      if (p > (128'd1 << 40)) p = 128'd1 << 40;
      return p;
   endfunction

   function automatic longint clamp_word(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint drift(longint p, longint v, inout logic flag);
      longint unsigned m;
      m = ((v < 0 ? longint'(-v) : v) * longint'(step_reg)) >> FRAC;
      return clamp_word(p + (v < 0 ? -longint'(m) : longint'(m)), flag);
   endfunction

   function automatic body_state_type euler_step(longint sx, longint sy, longint vx,
                                                 longint vy, longint ox, longint oy,
                                                 logic [31:0] mass);
      body_state_type o;
      longint         dx, dy, nvx, nvy;
      logic [127:0]   adx, ady, r2, r, den, gm, kx, ky;
      logic           sat;
      dx  = sx - ox;
      dy  = sy - oy;
      sat = 1'b0;
      nvx = vx;
      nvy = vy;
      o.coinc = (dx == 0 && dy == 0);
      if (!o.coinc) begin
         adx = 128'(dx < 0 ? -dx : dx);
         ady = 128'(dy < 0 ? -dy : dy);
         r2  = adx * adx + ady * ady;
         r   = root_floor(r2);
         den = r2 * r;
         gm  = 128'(grav_reg) * 128'(mass);
         kx  = kick_mag(adx, den, gm);
         ky  = kick_mag(ady, den, gm);
         nvx = clamp_word(vx + (dx > 0 ? -longint'(kx) : longint'(kx)), sat);
         nvy = clamp_word(vy + (dy > 0 ? -longint'(ky) : longint'(ky)), sat);
      end
      o.x   = 32'(drift(sx, nvx, sat));
      o.y   = 32'(drift(sy, nvy, sat));
      o.vx  = 32'(nvx);
      o.vy  = 32'(nvy);
      o.sat = sat;
      return o;
   endfunction

   task automatic report(string what, longint exp_v, longint act_v);
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      body_state_type e;
      if (reset) begin
         step_reg   <= REG_W'(65536);
         grav_reg   <= REG_W'(4374);
         body_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_TIME_STEP) step_reg <= csr_wdata;
            else if (csr_index == CSR_GRAVITY) grav_reg <= csr_wdata;
         end
         if (req_valid && !req_stall)
            body_queue.push_back(euler_step(req_self_x, req_self_y, req_self_vel_x,
                                            req_self_vel_y, req_other_x, req_other_y,
                                            req_other_mass));
         if (rsp_valid && !rsp_stall) begin
            if (body_queue.size() == 0) begin
               $display("%0t unexpected result word: expected none actual x=%0d",
                        $time, rsp_new_x);
               fail_count++;
            end else begin
               e = body_queue.pop_front();
               if (rsp_new_x !== e.x) report("new_x", e.x, rsp_new_x);
               if (rsp_new_y !== e.y) report("new_y", e.y, rsp_new_y);
               if (rsp_new_vel_x !== e.vx) report("new_vel_x", e.vx, rsp_new_vel_x);
               if (rsp_new_vel_y !== e.vy) report("new_vel_y", e.vy, rsp_new_vel_y);
               if (rsp_coincident !== e.coinc)
                  report("coincident", e.coinc, rsp_coincident);
               if (rsp_saturated !== e.sat) report("saturated", e.sat, rsp_saturated);
            end
         end
      end
      pending_count = body_queue.size();
   end

endmodule

[tb/tb_top.sv]
module tb_top;
   import tbges_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 111;
   localparam int STALL_LIMIT = 5000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TIME_STEP;
   logic [REG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [31:0]   req_self_x = '0, req_self_y = '0;
   logic signed [31:0]   req_self_vel_x = '0, req_self_vel_y = '0;
   logic signed [31:0]   req_other_x = '0, req_other_y = '0;
   logic [31:0]          req_other_mass = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [31:0]   rsp_new_x, rsp_new_y, rsp_new_vel_x, rsp_new_vel_y;
   logic                 rsp_coincident, rsp_saturated;
   int                   fail_count;
   int                   pending_count;
   int                   hold_request = 0;
   bit                   quiet = 1'b0;
   int                   idle_cycles = 0;

   always #5 clock = ~clock;

   two_body_gravity_euler_step uut (.*);

   gravity_step_checker checker_i (.*);

   // receiver: random stalls, a long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            stall_left = $urandom_range(20, 80);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 20);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || csr_wen)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_body(logic [31:0] sx, logic [31:0] sy, logic [31:0] vx,
                            logic [31:0] vy, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] mass);
      int gap;
      req_self_x     <= sx;
      req_self_y     <= sy;
      req_self_vel_x <= vx;
      req_self_vel_y <= vy;
      req_other_x    <= ox;
      req_other_y    <= oy;
      req_other_mass <= mass;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (quiet) gap = 0;
      else if ($urandom_range(0, 99) < 3) gap = $urandom_range(20, 60);
      else if ($urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
      else gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= REG_W'(val);
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] near_offset();
      return $signed($urandom) >>> $urandom_range(0, 31);
   endfunction

   task automatic send_random_body();
      logic [31:0] sx, sy, vx, vy, ox, oy, m;
      int          kind;
      kind = $urandom_range(0, 9);
      ox = $urandom;
      oy = $urandom;
      m  = $urandom >> $urandom_range(0, 31);
      vx = near_offset();
      vy = near_offset();
      sx = ox + near_offset();
      sy = oy + near_offset();
      case (kind)
         0, 1: begin
            sx = $urandom; sy = $urandom; vx = $urandom; vy = $urandom; m = $urandom;
         end
         7: begin
            sx = ox; sy = oy;
         end
         8: begin
            if ($urandom_range(0, 1)) sx = ox;
            else sy = oy;
         end
         9: begin
            sx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            vx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            m  = 32'hFFFF_FFFF;
         end
         default: ;
      endcase
      send_body(sx, sy, vx, vy, ox, oy, m);
   endtask

   initial begin
      int unsigned ts_set[7];
      int unsigned g_set[7];
      ts_set = '{65536, 1048576, 0, 1048576, 0, 0, 0};
      g_set  = '{4374, 1048576, 1048576, 0, 0, 0, 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset register values
      quiet = 1'b1;
      send_body(0, 0, 0, 0, 0, 0, 0);
      send_body(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_0100);
      send_body(32'h1234_0000, 32'h0567_0000, 32'h0003_0000, 32'hFFFD_0000,
                32'h1234_0000, 32'h0567_0000, 32'hFFFF_FFFF);
      send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_body(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_body(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_body(32'h0000_0010, 32'h0000_0010, 32'h7FFF_FFF0, 32'h8000_0010,
                0, 0, 32'h00FF_0000);
      send_body(32'h7FFF_0000, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_0000, 0, 0);
      send_body(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 32'hFFFF_8000,
                0, 0, 32'h0000_0000);
      send_body(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000,
                32'hFFFE_0000, 32'hFFFD_0000, 32'h0100_0000);
      quiet = 1'b0;
      for (int i = 0; i < 150; i++) send_random_body();

      for (int ph = 0; ph < 7; ph++) begin
         drain_pipe();
         if (ph >= 4) begin
            ts_set[ph] = $urandom_range(0, 1048576) >> $urandom_range(0, 8);
            g_set[ph]  = $urandom_range(0, 1048576) >> $urandom_range(0, 12);
         end
         write_reg(CSR_TIME_STEP, ts_set[ph]);
         write_reg(CSR_GRAVITY, g_set[ph]);
         // out-of-range indexes must be ignored
         if (ph == 2) write_reg(2'd2, $urandom_range(0, 1048576));
         if (ph == 5) write_reg(2'd3, $urandom_range(0, 1048576));
         if (ph == 1) begin
            hold_request = 400;
            for (int i = 0; i < 6; i++) send_body(0, 0, 0, 0, 0, 0, 0);
         end
         if (ph == 2) begin
            send_body(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0000_0100);
            send_body(32'h0005_0000, 0, 32'h0002_0000, 0, 0, 0, 32'h0000_0100);
         end
         quiet = (ph == 3);
         for (int i = 0; i < 175; i++) send_random_body();
         quiet = 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
